[rtl/svm_pkg.sv]
// shared types, widths and codes of the stereo voice mixer
// no dependencies; imported by svm_ctrl, svm_lane, stereo_voice_mixer_unit and the bench
package svm_pkg;

  localparam int POSITION_BITS = 24;
  localparam int POS_OUT_BITS  = 24;
  localparam int FRAMES_BITS   = 24;
  localparam int CMP_BITS      = (POSITION_BITS > FRAMES_BITS) ? POSITION_BITS : FRAMES_BITS;

  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_BITS  = 16;
  localparam int PAN_BITS    = 13;
  localparam int GAIN_BITS   = LEVEL_BITS + PAN_BITS;
  localparam int FRAC_BITS   = 24;
  localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int CFG_BITS    = 24;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [PAN_BITS-1:0] PAN_UNITY = PAN_BITS'(4096);

  // command codes
  localparam logic [1:0] CMD_MIX   = 2'd0;
  localparam logic [1:0] CMD_PLAY  = 2'd1;
  localparam logic [1:0] CMD_PAUSE = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAN     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOOPING = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAMES  = 2'd3;

  typedef struct packed {
    logic                   looping;
    logic [FRAMES_BITS-1:0] stream_frames;
  } seq_cfg_t;

  typedef struct packed {
    logic                    mix_en;
    logic                    is_playing;
    logic [POS_OUT_BITS-1:0] position;
  } status_t;

endpackage

[rtl/svm_ctrl.sv]
// voice sequencer: play state, playhead, rewind and stream end handling
// depends on svm_pkg
module svm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        command,
  input  svm_pkg::seq_cfg_t cfg,
  output svm_pkg::status_t  status
);
  import svm_pkg::*;

  logic [POSITION_BITS-1:0] playhead_r, playhead_nxt;
  logic                     playing_r, playing_nxt;
  logic                     active_r, active_nxt;
  logic                     rewind_r, rewind_nxt;
  logic [POSITION_BITS-1:0] ph_base, ph_inc;
  logic [CMP_BITS-1:0]      inc_ext, ph_ext;
  logic                     mix_en;

  assign ph_base = rewind_r ? '0 : playhead_r;
  assign ph_inc  = ph_base + POSITION_BITS'(1);
  assign inc_ext = CMP_BITS'(ph_inc);

  always_comb begin
    playhead_nxt = playhead_r;
    playing_nxt  = playing_r;
    active_nxt   = active_r;
    rewind_nxt   = rewind_r;
    mix_en       = 1'b0;
    unique case (command)
      CMD_PLAY: begin
        playing_nxt = 1'b1;
        if (!active_r) begin
          active_nxt = 1'b1;
        end else begin
          rewind_nxt = 1'b1;
        end
      end
      CMD_PAUSE: begin
        playing_nxt = 1'b0;
      end
      CMD_STOP: begin
        playing_nxt = 1'b0;
        rewind_nxt  = 1'b1;
      end
      default: begin
        if (active_r) begin
          rewind_nxt   = 1'b0;
          playhead_nxt = ph_base;
          if (playing_r) begin
            mix_en = 1'b1;
            // wrap at stream end, stop unless looping
            if (inc_ext >= CMP_BITS'(cfg.stream_frames)) begin
              playhead_nxt = '0;
              if (!cfg.looping) begin
                playing_nxt = 1'b0;
              end
            end else begin
              playhead_nxt = ph_inc;
            end
          end
          if (!playing_nxt) begin
            active_nxt = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playhead_r <= '0;
      playing_r  <= 1'b0;
      active_r   <= 1'b0;
      rewind_r   <= 1'b0;
    end else if (accept) begin
      playhead_r <= playhead_nxt;
      playing_r  <= playing_nxt;
      active_r   <= active_nxt;
      rewind_r   <= rewind_nxt;
    end
  end

  assign ph_ext            = CMP_BITS'(playhead_nxt);
  assign status.mix_en     = mix_en;
  assign status.is_playing = playing_nxt;
  assign status.position   = ph_ext[POS_OUT_BITS-1:0];

endmodule

[rtl/svm_lane.sv]
// one channel lane: gain product, sample scaling, add to mix, truncate and saturate
// depends on svm_pkg; three register stages with per-stage load enables
module svm_lane (
  input  logic                                clk,
  input  logic                                ld1,
  input  logic                                ld2,
  input  logic                                ld3,
  input  logic                                mix_en,
  input  logic [svm_pkg::PAN_BITS-1:0]        factor,
  input  logic [svm_pkg::LEVEL_BITS-1:0]      level,
  input  logic signed [svm_pkg::SAMPLE_BITS-1:0] mix,
  input  logic signed [svm_pkg::SAMPLE_BITS-1:0] sample,
  output logic signed [svm_pkg::SAMPLE_BITS-1:0] result
);
  import svm_pkg::*;

  localparam int QUO_BITS = PROD_BITS - FRAC_BITS;

  // stage 1: gain
  logic [GAIN_BITS-1:0]          gain_r;
  logic signed [SAMPLE_BITS-1:0] sample1_r, mix1_r;
  logic                          en1_r;
  // stage 2: scaled sample
  logic signed [PROD_BITS-1:0]   prod_r;
  logic signed [SAMPLE_BITS-1:0] mix2_r;
  logic                          en2_r;
  // stage 3: result
  logic signed [SAMPLE_BITS-1:0] result_r, result_nxt;

  logic signed [PROD_BITS-1:0]   prod_nxt, acc;
  logic signed [QUO_BITS-1:0]    quo;
  logic                          round_up;

  // operands widened to the full product width before the multiply
  assign prod_nxt = PROD_BITS'(sample1_r) * $signed(PROD_BITS'({1'b0, gain_r}));

  always_ff @(posedge clk) begin
    if (ld1) begin
      gain_r    <= GAIN_BITS'(factor) * GAIN_BITS'(level);
      sample1_r <= sample;
      mix1_r    <= mix;
      en1_r     <= mix_en;
    end
    if (ld2) begin
      prod_r <= prod_nxt;
      mix2_r <= mix1_r;
      en2_r  <= en1_r;
    end
    if (ld3) begin
      result_r <= result_nxt;
    end
  end

  // mix * 2^24 + product, then divide by 2^24 toward zero
  assign acc      = prod_r + ($signed(PROD_BITS'(mix2_r)) <<< FRAC_BITS);
  assign round_up = acc[PROD_BITS-1] && (acc[FRAC_BITS-1:0] != '0);
  assign quo      = acc[PROD_BITS-1:FRAC_BITS] + QUO_BITS'(round_up);

  always_comb begin
    if (!en2_r) begin
      result_nxt = mix2_r;
    end else if (quo > QUO_BITS'(32767)) begin
      result_nxt = 16'sh7FFF;
    end else if (quo < -QUO_BITS'(32768)) begin
      result_nxt = -16'sh8000;
    end else begin
      result_nxt = quo[SAMPLE_BITS-1:0];
    end
  end

  assign result = result_r;

endmodule

[rtl/stereo_voice_mixer_unit.sv]
// top level of one stereo mixer voice: config registers, sequencer, two channel lanes
// depends on svm_pkg, svm_ctrl, svm_lane

// One playback voice of a stereo mixer. Each request on the in_ side carries a command in
// in_tuser (mix frame, play, pause, stop) and a running stereo mix plus this voice's sample
// pair in in_tdata; each request gives exactly one result on the out_ side with the new mix,
// the play flag and the playhead. A new request can be taken every cycle while the out_ side
// does not stall; results pass through the lane pipeline registers (gain product,
// sample multiply, add/truncate/saturate). The voice state (play flag, playhead, rewind)
// is updated in the cycle a request is taken, so back to back requests see each other.
// Gains are (4096 - pan) * level for left and pan * level for right; pan writes above 4096
// are clipped. Configuration writes take effect on the next edge and must only happen while
// no request is in flight.
module stereo_voice_mixer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // mix_left, mix_right, sample_left, sample_right
  input  logic [1:0]  in_tuser,   // command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_left, out_right, is_playing, position, zero pad
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [svm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [svm_pkg::CFG_BITS-1:0]     cfg_wdata
);
  import svm_pkg::*;

  // configuration registers
  logic [LEVEL_BITS-1:0]  level_r;
  logic [PAN_BITS-1:0]    pan_r;
  logic                   looping_r;
  logic [FRAMES_BITS-1:0] frames_r;
  logic [PAN_BITS-1:0]    pan_wr;
  seq_cfg_t               seq_cfg;

  // pipeline valids and status pipeline
  logic    v1_r, v2_r, v3_r;
  logic    ld1, ld2, ld3, accept;
  status_t status, st1_r, st2_r, st3_r;

  logic signed [SAMPLE_BITS-1:0] res_left, res_right;
  logic [PAN_BITS-1:0]           left_factor;

  // pan saturates to unity on write
  assign pan_wr = (cfg_wdata[PAN_BITS-1:0] > PAN_UNITY) ? PAN_UNITY : cfg_wdata[PAN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= LEVEL_BITS'(4096);
      pan_r     <= PAN_BITS'(2048);
      looping_r <= 1'b0;
      frames_r  <= FRAMES_BITS'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LEVEL:   level_r   <= cfg_wdata[LEVEL_BITS-1:0];
        REG_PAN:     pan_r     <= pan_wr;
        REG_LOOPING: looping_r <= cfg_wdata[0];
        REG_FRAMES:  frames_r  <= cfg_wdata[FRAMES_BITS-1:0];
        default:     level_r   <= level_r;
      endcase
    end
  end

  assign seq_cfg.looping       = looping_r;
  assign seq_cfg.stream_frames = frames_r;

  // each stage loads when it is empty or its contents move on
  assign ld3       = !v3_r || out_tready;
  assign ld2       = !v2_r || ld3;
  assign ld1       = !v1_r || ld2;
  assign in_tready = ld1;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_tvalid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) st1_r <= status;
    if (ld2) st2_r <= st1_r;
    if (ld3) st3_r <= st2_r;
  end

  svm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .command (in_tuser),
    .cfg     (seq_cfg),
    .status  (status)
  );

  assign left_factor = PAN_UNITY - pan_r;

  // left and right lanes run in lock step
  svm_lane u_lane_left (
    .clk    (clk),
    .ld1    (ld1),
    .ld2    (ld2),
    .ld3    (ld3),
    .mix_en (status.mix_en),
    .factor (left_factor),
    .level  (level_r),
    .mix    ($signed(in_tdata[15:0])),
    .sample ($signed(in_tdata[47:32])),
    .result (res_left)
  );

  svm_lane u_lane_right (
    .clk    (clk),
    .ld1    (ld1),
    .ld2    (ld2),
    .ld3    (ld3),
    .mix_en (status.mix_en),
    .factor (pan_r),
    .level  (level_r),
    .mix    ($signed(in_tdata[31:16])),
    .sample ($signed(in_tdata[63:48])),
    .result (res_right)
  );

  // merge lane results with the sequencer status
  assign out_tvalid = v3_r;
  assign out_tdata  = {7'd0, st3_r.position, st3_r.is_playing, res_right, res_left};

endmodule

[bench/tb_stereo_voice_mixer_unit.sv]
`timescale 1ns / 1ps
// self-checking bench for stereo_voice_mixer_unit: random and directed voice requests
// depends on svm_pkg and the stereo_voice_mixer_unit rtl
module tb_stereo_voice_mixer_unit;
  import svm_pkg::*;

  localparam int     LATENCY   = 3;
  localparam int     LONG_HOLD = 200;
  localparam longint FRAC_ONE  = longint'(1) << FRAC_BITS;

  // one request as the sender sees it
  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] mix_l;
    logic signed [15:0] mix_r;
    logic signed [15:0] smp_l;
    logic signed [15:0] smp_r;
  } voice_req_t;

  // one mixed frame as the block should return it
  typedef struct {
    logic signed [15:0]      left;
    logic signed [15:0]      right;
    logic                    playing;
    logic [POS_OUT_BITS-1:0] pos;
  } mixed_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // mix_left, mix_right, sample_left, sample_right
  logic [1:0]  in_tuser = '0;   // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // out_left, out_right, is_playing, position, zero pad
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_wdata = '0;

  stereo_voice_mixer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // shadow registers, as the block holds them after a write
  logic [LEVEL_BITS-1:0]  r_level   = 16'd4096;
  logic [PAN_BITS-1:0]    r_pan     = 13'd2048;
  logic                   r_looping = 1'b0;
  logic [FRAMES_BITS-1:0] r_frames  = 24'd1;

  // shadow voice state
  logic [POSITION_BITS-1:0] v_playhead = '0;
  logic                     v_playing  = 1'b0;
  logic                     v_active   = 1'b0;
  logic                     v_rewind   = 1'b0;

  voice_req_t   pending_reqs[$];
  mixed_frame_t mixed_frames_q[$];
  int reqs_queued = 0;
  int reqs_taken = 0;
  int results_seen = 0;
  int errors = 0;

  // mix + sample * gain with 24 fraction bits, truncated toward zero, clipped to 16 bits
  function automatic logic signed [15:0] add_scaled(logic signed [15:0] mix,
                                                    logic signed [15:0] smp, longint gain);
    longint acc;
    longint q;
    acc = longint'(mix) * FRAC_ONE + longint'(smp) * gain;
    q = acc / FRAC_ONE;
    if (q < -32768) q = -32768;
    else if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  // advance the shadow voice by one taken request and queue the frame it yields
  function automatic void mix_voice_step(voice_req_t rq);
    mixed_frame_t res;
    logic [POSITION_BITS-1:0] nxt;
    res.left  = rq.mix_l;
    res.right = rq.mix_r;
    case (rq.cmd)
      CMD_PLAY: begin
        v_playing = 1'b1;
        // play on an active voice restarts it at the next mix frame
        if (!v_active) v_active = 1'b1;
        else v_rewind = 1'b1;
      end
      CMD_PAUSE: v_playing = 1'b0;
      CMD_STOP: begin
        v_rewind  = 1'b1;
        v_playing = 1'b0;
      end
      CMD_MIX: if (v_active) begin
        // rewind lands before the samples are used
        if (v_rewind) begin
          v_playhead = '0;
          v_rewind   = 1'b0;
        end
        if (v_playing) begin
          res.left  = add_scaled(rq.mix_l, rq.smp_l,
                                 (longint'(PAN_UNITY) - longint'(r_pan)) * longint'(r_level));
          res.right = add_scaled(rq.mix_r, rq.smp_r, longint'(r_pan) * longint'(r_level));
          nxt = v_playhead + 1'b1;
          // end of stream, a zero length wraps every frame
          if (nxt >= r_frames) begin
            nxt = '0;
            if (!r_looping) v_playing = 1'b0;
          end
          v_playhead = nxt;
        end
        // a paused voice drops out of the mix
        if (!v_playing) v_active = 1'b0;
      end
    endcase
    res.playing = v_playing;
    res.pos     = v_playhead[POS_OUT_BITS-1:0];
    mixed_frames_q.push_back(res);
  endfunction

  // sender: one request in flight, a random gap after each, stretches without gaps
  voice_req_t tx_cur;
  logic tx_fire;
  logic tx_next_valid;
  int   tx_gap = 0;
  int   tx_run_left = 0;
  logic tx_idling = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      tx_fire = in_tvalid && in_tready;
      if (tx_fire) begin
        mix_voice_step(tx_cur);
        reqs_taken++;
      end
      if (in_tvalid && !tx_fire) begin
        tx_next_valid = 1'b1;
      end else if (tx_gap != 0) begin
        tx_gap--;
        tx_next_valid = 1'b0;
      end else if (pending_reqs.size() != 0) begin
        tx_cur = pending_reqs.pop_front();
        in_tdata <= {tx_cur.smp_r, tx_cur.smp_l, tx_cur.mix_r, tx_cur.mix_l};
        in_tuser <= tx_cur.cmd;
        tx_next_valid = 1'b1;
        if (tx_run_left == 0) begin
          tx_run_left = $urandom_range(5, 60);
          tx_idling   = ($urandom_range(0, 2) != 0);
        end
        tx_run_left--;
        tx_gap = tx_idling ? $urandom_range(0, 11) : 0;
      end else begin
        tx_next_valid = 1'b0;
      end
      in_tvalid <= tx_next_valid;
    end
  end

  // receiver: checks each frame, stalls at random, twice holds off for a long stretch
  mixed_frame_t want;
  mixed_frame_t got;
  logic [6:0] got_pad;
  int   rx_wait = 0;
  int   rx_run_left = 0;
  logic rx_idling = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.left    = out_tdata[15:0];
        got.right   = out_tdata[31:16];
        got.playing = out_tdata[32];
        got.pos     = out_tdata[56:33];
        got_pad     = out_tdata[63:57];
        if (mixed_frames_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("frame %0d with no request waiting: L=%0d R=%0d play=%0b pos=%0d",
                     results_seen, got.left, got.right, got.playing, got.pos);
        end else begin
          want = mixed_frames_q.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.playing !== want.playing || got.pos !== want.pos || got_pad !== '0) begin
            errors++;
            if (errors <= 10)
              $display({"frame %0d mismatch: expected L=%0d R=%0d play=%0b pos=%0d, ",
                        "got L=%0d R=%0d play=%0b pos=%0d pad=%h"}, results_seen,
                       want.left, want.right, want.playing, want.pos,
                       got.left, got.right, got.playing, got.pos, got_pad);
          end
        end
        if (rx_run_left == 0) begin
          rx_run_left = $urandom_range(5, 60);
          rx_idling   = ($urandom_range(0, 2) != 0);
        end
        rx_run_left--;
        rx_wait = rx_idling ? $urandom_range(0, 11) : 0;
        // long hold-off while the sender keeps offering, backs the block up
        if (results_seen == 400 || results_seen == 900) rx_wait = LONG_HOLD;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_tready <= (rx_wait == 0);
    end
  end

  task automatic send(logic [1:0] cmd, logic signed [15:0] ml, logic signed [15:0] mr,
                      logic signed [15:0] sl, logic signed [15:0] sr);
    voice_req_t rq;
    rq.cmd   = cmd;
    rq.mix_l = ml;
    rq.mix_r = mr;
    rq.smp_l = sl;
    rq.smp_r = sr;
    pending_reqs.push_back(rq);
    reqs_queued++;
  endtask

  // wait until every request is taken and answered, then let the pipeline drain
  task automatic drain_voice();
    do @(posedge clk);
    while (reqs_taken != reqs_queued || mixed_frames_q.size() != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LEVEL:   r_level = val[LEVEL_BITS-1:0];
      REG_PAN:     r_pan = (val[PAN_BITS-1:0] > PAN_UNITY) ? PAN_UNITY : val[PAN_BITS-1:0];
      REG_LOOPING: r_looping = val[0];
      REG_FRAMES:  r_frames = val[FRAMES_BITS-1:0];
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly random audio, sometimes the rails and the values around zero
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 19))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  logic [1:0]          rnd_cmd;
  int                  pick;
  logic [CFG_BITS-1:0] p_level, p_pan, p_loop, p_frames;

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: inactive pass-through, play, restart, pause, stop
    send(CMD_MIX,   16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send(CMD_PAUSE, 16'sh1234, -16'sd5,   16'sh0,    16'sh0);
    send(CMD_STOP,  16'sh8000, 16'sh7fff, 16'sh0,    16'sh0);
    send(CMD_PLAY,  16'sd100,  -16'sd100, 16'sh0,    16'sh0);
    send(CMD_MIX,   16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send(CMD_PLAY,  16'sd0,    16'sd0,    16'sh0,    16'sh0);
    send(CMD_PLAY,  16'sd0,    16'sd0,    16'sh0,    16'sh0);
    send(CMD_MIX,   -16'sd3,   16'sd3,    -16'sd1,   16'sd1);
    send(CMD_PAUSE, 16'sd7,    16'sd7,    16'sh0,    16'sh0);
    send(CMD_MIX,   16'sd9,    -16'sd9,   16'sd500,  16'sd500);
    drain_voice();

    // max level, pan written above unity, looping over a short stream
    write_reg(REG_LEVEL, 24'd65535);
    write_reg(REG_PAN, 24'd8191);
    write_reg(REG_LOOPING, 24'd1);
    write_reg(REG_FRAMES, 24'd3);
    send(CMD_PLAY,  16'sd0,    16'sd0,    16'sh0,    16'sh0);
    send(CMD_MIX,   16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send(CMD_MIX,   16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
    send(CMD_MIX,   16'sd0,    16'sd0,    16'sh0001, 16'shffff);
    send(CMD_MIX,   16'sd0,    16'sd0,    16'sh7fff, 16'sh7fff);
    send(CMD_STOP,  16'sd1,    16'sd2,    16'sh0,    16'sh0);
    send(CMD_PLAY,  16'sd3,    16'sd4,    16'sh0,    16'sh0);
    send(CMD_MIX,   16'sd5,    16'sd6,    16'sh4000, -16'sd1);
    drain_voice();

    // silent voice on a zero length stream
    write_reg(REG_LEVEL, 24'd0);
    write_reg(REG_PAN, 24'd0);
    write_reg(REG_LOOPING, 24'd0);
    write_reg(REG_FRAMES, 24'd0);
    send(CMD_PLAY,  16'sd0,    16'sd0,    16'sh0,    16'sh0);
    send(CMD_MIX,   16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send(CMD_MIX,   16'sd11,   16'sd12,   16'sh7fff, 16'sh7fff);

    // random phases, each with its own register settings
    for (int ph = 0; ph < 6; ph++) begin
      drain_voice();
      case (ph)
        0: begin
          p_level = CFG_BITS'(4096); p_pan = CFG_BITS'($urandom_range(0, 4096));
          p_loop = CFG_BITS'(1); p_frames = CFG_BITS'($urandom_range(1, 8));
        end
        1: begin
          p_level = CFG_BITS'(65535); p_pan = '0; p_loop = '0;
          p_frames = CFG_BITS'($urandom_range(1, 24));
        end
        2: begin
          p_level = CFG_BITS'($urandom_range(0, 65535)); p_pan = CFG_BITS'(4096);
          p_loop = CFG_BITS'(1); p_frames = 24'hffffff;
        end
        3: begin
          p_level = '0; p_pan = CFG_BITS'($urandom_range(0, 8191));
          p_loop = CFG_BITS'(1); p_frames = '0;
        end
        4: begin
          p_level = CFG_BITS'($urandom_range(0, 65535));
          p_pan = CFG_BITS'($urandom_range(0, 8191));
          p_loop = CFG_BITS'($urandom_range(0, 1));
          p_frames = CFG_BITS'($urandom_range(1, 40));
        end
        default: begin
          p_level = CFG_BITS'(65535); p_pan = CFG_BITS'($urandom_range(4097, 8191));
          p_loop = '0; p_frames = CFG_BITS'(2);
        end
      endcase
      write_reg(REG_LEVEL, p_level);
      write_reg(REG_PAN, p_pan);
      write_reg(REG_LOOPING, p_loop);
      write_reg(REG_FRAMES, p_frames);
      for (int n = 0; n < 188; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) rnd_cmd = CMD_MIX;
        else if (pick < 86) rnd_cmd = CMD_PLAY;
        else if (pick < 93) rnd_cmd = CMD_PAUSE;
        else rnd_cmd = CMD_STOP;
        send(rnd_cmd, pick_sample(), pick_sample(), pick_sample(), pick_sample());
      end
    end
    drain_voice();

    if (errors == 0) begin
      $display("PASS stereo_voice_mixer_unit");
    end else begin
      $display("FAIL stereo_voice_mixer_unit");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #400000;
    $display("FAIL stereo_voice_mixer_unit");
    $finish;
  end

endmodule

[files.f]
rtl/svm_pkg.sv
rtl/svm_ctrl.sv
rtl/svm_lane.sv
rtl/stereo_voice_mixer_unit.sv
bench/tb_stereo_voice_mixer_unit.sv
